>>> rtl/vpid_pkg.sv
// shared types and constants of the velocity pid thrust unit
package vpid_pkg;

    localparam int IN_W   = 192;
    localparam int OUT_W  = 48;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 48;

    localparam logic [CIDX_W-1:0] CFG_DOWN_GAINS  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_HORIZ_GAINS = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_HOVER       = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MIN_THRUST  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MAX_THRUST  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_TILT        = 3'd5;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD,
        OP_D1, OP_D2, OP_D3, OP_D4, OP_D5,
        OP_M1, OP_M2,
        OP_H1, OP_H2, OP_H3, OP_H4, OP_H5, OP_H6,
        OP_SQ_EXC,
        OP_H8, OP_H9, OP_H10, OP_H11, OP_H12,
        OP_EVAL, OP_SQ_MAG, OP_MAGN, OP_DIV, OP_QN, OP_QE,
        OP_I1, OP_I2, OP_I3, OP_I4, OP_I5, OP_I6,
        OP_SQ_INT, OP_I7, OP_KEEP, OP_QA, OP_QB,
        OP_OUT
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_D1, ST_D2, ST_D3, ST_D4, ST_D5,
        ST_M1, ST_M2,
        ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
        ST_SQX, ST_WX,
        ST_H8, ST_H9, ST_H10, ST_H11, ST_H12,
        ST_EVAL, ST_SQM, ST_WM, ST_MAGN,
        ST_DVN, ST_WDN, ST_QN, ST_DVE, ST_WDE, ST_QE,
        ST_HINT,
        ST_I1, ST_I2, ST_I3, ST_I4, ST_I5, ST_I6,
        ST_SQA, ST_WA, ST_I7, ST_KEEP,
        ST_DVA, ST_WDA, ST_QA, ST_DVB, ST_WDB, ST_QB,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic manual;
        logic big;
        logic mag_gt;
        logic stop_h;
        logic sqrt_done;
        logic div_done;
    } sts_t;

endpackage

>>> rtl/vpid_sqrt.sv
// iterative integer square root, one result bit per cycle
module vpid_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

>>> rtl/vpid_div.sv
// restoring divider, quotient known to stay below 2^26, truncates toward zero
module vpid_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [57:0] num,
    input  logic [31:0]        den,
    output logic               done,
    output logic signed [26:0] quot
);

    logic [57:0] rem_reg;
    logic [57:0] dsh_reg;
    logic [25:0] q_reg;
    logic        neg_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd25)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[57] ? 58'(-num) : 58'(num);
            dsh_reg <= {1'b0, den, 25'b0};
            q_reg   <= '0;
            neg_reg <= num[57];
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[24:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[24:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

>>> rtl/vpid_datapath.sv
// datapath: configuration, integrators, shared multiplier, sqrt and divide units
module vpid_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  vpid_pkg::cmd_t                 cmd,
    output vpid_pkg::sts_t                 sts,
    input  logic [vpid_pkg::IN_W-1:0]      s_tdata,
    output logic [vpid_pkg::OUT_W-1:0]     m_tdata,
    output logic [1:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic [vpid_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [vpid_pkg::CDAT_W-1:0]    cfg_data
);

    logic [47:0] dgain_reg, hgain_reg;
    logic [14:0] hover_reg, min_reg, max_reg;
    logic [15:0] tilt_tan_reg;

    logic signed [31:0] integ_n_reg, integ_e_reg, integ_d_reg;

    logic signed [15:0] sp_n_reg, sp_e_reg;
    logic signed [16:0] err_n_reg, err_e_reg, err_d_reg;
    logic signed [15:0] acn_reg, ace_reg, acd_reg;
    logic signed [15:0] man_n_reg, man_e_reg;
    logic [15:0]        dt_reg;

    logic signed [67:0] acc_reg;
    logic signed [33:0] t_reg;
    logic signed [31:0] td_reg;
    logic               stop_d_reg;
    logic signed [15:0] thr_d_reg;
    logic [18:0]        tilt_reg;
    logic signed [31:0] des_n_reg, des_e_reg;
    logic [14:0]        tmax_reg;
    logic [29:0]        tsq_reg;
    logic signed [35:0] dir_reg;
    logic               stop_h_reg;
    logic signed [31:0] a_reg, b_reg;
    logic [31:0]        mag_reg;
    logic signed [15:0] w_thr_n_reg, w_thr_e_reg;
    logic signed [15:0] o_thr_n_reg, o_thr_e_reg, o_thr_d_reg;
    logic               o_dwin_reg, o_hwin_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic               sq_start, dv_start, sq_done, dv_done;
    logic [63:0]        sq_value;
    logic [31:0]        sq_root;
    logic signed [26:0] dv_quot;

    logic signed [31:0] umax, umin;
    logic               stop_d_next;
    logic signed [31:0] thr_d_next;
    logic signed [39:0] dsum, dlim;
    logic signed [33:0] abs_thr_d;
    logic [25:0]        lim;

    function automatic logic signed [15:0] sat16(input logic signed [67:0] v);
        if (v < -68'sd32768)
            return -16'sd32768;
        else if (v > 68'sd32767)
            return 16'sd32767;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v < -40'sd2147483648)
            return 32'h8000_0000;
        else if (v > 40'sd2147483647)
            return 32'h7FFF_FFFF;
        else
            return v[31:0];
    endfunction

    assign lim       = {1'b0, tmax_reg, 10'b0};
    assign abs_thr_d = thr_d_reg[15] ? -34'(thr_d_reg) : 34'(thr_d_reg);
    assign umax      = -$signed(32'(min_reg));
    assign umin      = -$signed(32'(max_reg));

    // down axis anti-windup and clamp
    always_comb
    begin
        stop_d_next = ((td_reg >= umax) && !err_d_reg[16]) ||
                      ((td_reg <= umin) && (err_d_reg[16] || (err_d_reg == 17'sd0)));
        if (td_reg < umin)
            thr_d_next = umin;
        else if (td_reg > umax)
            thr_d_next = umax;
        else
            thr_d_next = td_reg;
        dlim = $signed(40'({max_reg, 10'b0}));
        dsum = 40'(integ_d_reg) + 40'(acc_reg >>> 12);
        if (dsum > dlim)
            dsum = dlim;
        else if (dsum < -dlim)
            dsum = -dlim;
    end

    // operand selection of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            vpid_pkg::OP_D1:   begin mul_a = 34'(err_d_reg); mul_b = $signed(34'(dgain_reg[15:0])); end
            vpid_pkg::OP_D2:   begin mul_a = 34'(acd_reg);   mul_b = $signed(34'(dgain_reg[47:32])); end
            vpid_pkg::OP_D3:   begin mul_a = 34'(err_d_reg); mul_b = $signed(34'(dgain_reg[31:16])); end
            vpid_pkg::OP_D4,
            vpid_pkg::OP_I2,
            vpid_pkg::OP_I4:   begin mul_a = t_reg;          mul_b = $signed(34'(dt_reg)); end
            vpid_pkg::OP_D5:   begin mul_a = abs_thr_d;      mul_b = $signed(34'(tilt_tan_reg)); end
            vpid_pkg::OP_M1:   begin mul_a = 34'(man_n_reg); mul_b = $signed(34'(tilt_reg)); end
            vpid_pkg::OP_M2:   begin mul_a = 34'(man_e_reg); mul_b = $signed(34'(tilt_reg)); end
            vpid_pkg::OP_H1:   begin mul_a = 34'(err_n_reg); mul_b = $signed(34'(hgain_reg[15:0])); end
            vpid_pkg::OP_H2:   begin mul_a = 34'(acn_reg);   mul_b = $signed(34'(hgain_reg[47:32])); end
            vpid_pkg::OP_H3:   begin mul_a = 34'(err_e_reg); mul_b = $signed(34'(hgain_reg[15:0])); end
            vpid_pkg::OP_H4:   begin mul_a = 34'(ace_reg);   mul_b = $signed(34'(hgain_reg[47:32])); end
            vpid_pkg::OP_H5:   begin mul_a = $signed(34'(max_reg)); mul_b = $signed(34'(max_reg)); end
            vpid_pkg::OP_H6:   begin mul_a = 34'(thr_d_reg); mul_b = 34'(thr_d_reg); end
            vpid_pkg::OP_H8:   begin mul_a = 34'(des_n_reg); mul_b = 34'(des_n_reg); end
            vpid_pkg::OP_H9:   begin mul_a = 34'(des_e_reg); mul_b = 34'(des_e_reg); end
            vpid_pkg::OP_H10:  begin mul_a = $signed(34'(tmax_reg)); mul_b = $signed(34'(tmax_reg)); end
            vpid_pkg::OP_H11:  begin mul_a = 34'(err_n_reg); mul_b = 34'(sp_n_reg); end
            vpid_pkg::OP_H12:  begin mul_a = 34'(err_e_reg); mul_b = 34'(sp_e_reg); end
            vpid_pkg::OP_MAGN: begin mul_a = 34'(des_n_reg); mul_b = $signed(34'(tmax_reg)); end
            vpid_pkg::OP_QN:   begin mul_a = 34'(des_e_reg); mul_b = $signed(34'(tmax_reg)); end
            vpid_pkg::OP_I1:   begin mul_a = 34'(err_n_reg); mul_b = $signed(34'(hgain_reg[31:16])); end
            vpid_pkg::OP_I3:   begin mul_a = 34'(err_e_reg); mul_b = $signed(34'(hgain_reg[31:16])); end
            vpid_pkg::OP_I5:   begin mul_a = 34'(a_reg);     mul_b = 34'(a_reg); end
            vpid_pkg::OP_I6:   begin mul_a = 34'(b_reg);     mul_b = 34'(b_reg); end
            vpid_pkg::OP_I7:   begin mul_a = 34'(a_reg);     mul_b = $signed(34'(lim)); end
            vpid_pkg::OP_QA:   begin mul_a = 34'(b_reg);     mul_b = $signed(34'(lim)); end
            default:           begin mul_a = '0;             mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        sq_start = 1'b0;
        dv_start = 1'b0;
        sq_value = acc_reg[63:0];
        case (cmd.op)
            vpid_pkg::OP_SQ_EXC:
            begin
                sq_start = 1'b1;
                // negative room gives no excess thrust
                sq_value = (acc_reg > 68'sd0) ? acc_reg[63:0] : 64'd0;
            end
            vpid_pkg::OP_SQ_MAG, vpid_pkg::OP_SQ_INT: sq_start = 1'b1;
            vpid_pkg::OP_DIV:                         dv_start = 1'b1;
            default:                                  sq_start = 1'b0;
        endcase
    end

    vpid_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root)
    );

    vpid_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (acc_reg[57:0]),
        .den   (mag_reg),
        .done  (dv_done),
        .quot  (dv_quot)
    );

    // configuration and integrators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dgain_reg    <= '0;
            hgain_reg    <= '0;
            hover_reg    <= 15'd8192;
            min_reg      <= 15'd1966;
            max_reg      <= 15'd16384;
            tilt_tan_reg <= 16'd4096;
            integ_n_reg  <= '0;
            integ_e_reg  <= '0;
            integ_d_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vpid_pkg::CFG_DOWN_GAINS:  dgain_reg    <= cfg_data;
                    vpid_pkg::CFG_HORIZ_GAINS: hgain_reg    <= cfg_data;
                    vpid_pkg::CFG_HOVER:       hover_reg    <= cfg_data[14:0];
                    vpid_pkg::CFG_MIN_THRUST:  min_reg      <= cfg_data[14:0];
                    vpid_pkg::CFG_MAX_THRUST:  max_reg      <= cfg_data[14:0];
                    vpid_pkg::CFG_TILT:        tilt_tan_reg <= cfg_data[15:0];
                    default:                   dgain_reg    <= dgain_reg;
                endcase
            end
            case (cmd.op)
                vpid_pkg::OP_D5:
                begin
                    if (!stop_d_reg)
                        integ_d_reg <= dsum[31:0];
                end
                vpid_pkg::OP_KEEP:
                begin
                    integ_n_reg <= a_reg;
                    integ_e_reg <= b_reg;
                end
                vpid_pkg::OP_QA: integ_n_reg <= 32'(dv_quot);
                vpid_pkg::OP_QB: integ_e_reg <= 32'(dv_quot);
                default:         integ_d_reg <= integ_d_reg;
            endcase
        end
    end

    // working registers of one transaction
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            vpid_pkg::OP_LOAD:
            begin
                sp_n_reg  <= $signed(s_tdata[15:0]);
                sp_e_reg  <= $signed(s_tdata[31:16]);
                err_n_reg <= 17'($signed(s_tdata[15:0])) - 17'($signed(s_tdata[63:48]));
                err_e_reg <= 17'($signed(s_tdata[31:16])) - 17'($signed(s_tdata[79:64]));
                err_d_reg <= 17'($signed(s_tdata[47:32])) - 17'($signed(s_tdata[95:80]));
                acn_reg   <= $signed(s_tdata[111:96]);
                ace_reg   <= $signed(s_tdata[127:112]);
                acd_reg   <= $signed(s_tdata[143:128]);
                man_n_reg <= $signed(s_tdata[159:144]);
                man_e_reg <= $signed(s_tdata[175:160]);
                dt_reg    <= s_tdata[191:176];
            end
            vpid_pkg::OP_D1:
                acc_reg <= (prod <<< 4) + 68'(integ_d_reg) - $signed(68'({hover_reg, 10'b0}));
            vpid_pkg::OP_D2, vpid_pkg::OP_H2, vpid_pkg::OP_H4:
                acc_reg <= acc_reg + (prod <<< 4);
            vpid_pkg::OP_D3:
            begin
                td_reg <= $signed(acc_reg[41:10]);
                t_reg  <= prod[33:0];
            end
            vpid_pkg::OP_D4:
            begin
                stop_d_reg <= stop_d_next;
                thr_d_reg  <= thr_d_next[15:0];
                acc_reg    <= prod;
            end
            vpid_pkg::OP_D5:
                tilt_reg <= prod[30:12];
            vpid_pkg::OP_M1:
                w_thr_n_reg <= sat16(prod >>> 14);
            vpid_pkg::OP_M2:
            begin
                w_thr_e_reg <= sat16(prod >>> 14);
                stop_h_reg  <= 1'b0;
            end
            vpid_pkg::OP_H1:
                acc_reg <= (prod <<< 4) + 68'(integ_n_reg);
            vpid_pkg::OP_H3:
            begin
                des_n_reg <= $signed(acc_reg[41:10]);
                acc_reg   <= (prod <<< 4) + 68'(integ_e_reg);
            end
            vpid_pkg::OP_H5:
            begin
                des_e_reg <= $signed(acc_reg[41:10]);
                acc_reg   <= prod;
            end
            vpid_pkg::OP_H6:
                acc_reg <= acc_reg - prod;
            vpid_pkg::OP_H8:
            begin
                tmax_reg <= (32'(tilt_reg) < sq_root) ? tilt_reg[14:0] : sq_root[14:0];
                acc_reg  <= prod;
            end
            vpid_pkg::OP_H9, vpid_pkg::OP_I6:
                acc_reg <= acc_reg + prod;
            vpid_pkg::OP_H10:
                tsq_reg <= prod[29:0];
            vpid_pkg::OP_H11:
                dir_reg <= prod[35:0];
            vpid_pkg::OP_H12:
                dir_reg <= dir_reg + prod[35:0];
            vpid_pkg::OP_EVAL:
            begin
                stop_h_reg  <= (acc_reg >= $signed(68'(tsq_reg))) && !dir_reg[35];
                w_thr_n_reg <= sat16(68'(des_n_reg));
                w_thr_e_reg <= sat16(68'(des_e_reg));
            end
            vpid_pkg::OP_MAGN, vpid_pkg::OP_I7:
            begin
                mag_reg <= sq_root;
                acc_reg <= prod;
            end
            vpid_pkg::OP_QN:
            begin
                w_thr_n_reg <= dv_quot[15:0];
                acc_reg     <= prod;
            end
            vpid_pkg::OP_QE:
                w_thr_e_reg <= dv_quot[15:0];
            vpid_pkg::OP_I1, vpid_pkg::OP_I3:
                t_reg <= prod[33:0];
            vpid_pkg::OP_I2:
                a_reg <= sat32(40'(integ_n_reg) + 40'(prod >>> 12));
            vpid_pkg::OP_I4:
                b_reg <= sat32(40'(integ_e_reg) + 40'(prod >>> 12));
            vpid_pkg::OP_I5, vpid_pkg::OP_QA:
                acc_reg <= prod;
            vpid_pkg::OP_OUT:
            begin
                o_thr_n_reg <= w_thr_n_reg;
                o_thr_e_reg <= w_thr_e_reg;
                o_thr_d_reg <= thr_d_reg;
                o_dwin_reg  <= stop_d_reg;
                o_hwin_reg  <= stop_h_reg;
            end
            default:
                acc_reg <= acc_reg;
        endcase
    end

    assign sts.manual    = (man_n_reg != 16'sd0) || (man_e_reg != 16'sd0);
    assign sts.big       = acc_reg > $signed(68'(tsq_reg));
    assign sts.mag_gt    = sq_root > 32'(lim);
    assign sts.stop_h    = stop_h_reg;
    assign sts.sqrt_done = sq_done;
    assign sts.div_done  = dv_done;

    assign m_tdata = {o_thr_d_reg, o_thr_e_reg, o_thr_n_reg};
    assign m_tuser = {o_hwin_reg, o_dwin_reg};

endmodule

>>> rtl/vpid_ctrl.sv
// controller: sequences the datapath steps and owns the stream handshakes
module vpid_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  vpid_pkg::sts_t sts,
    output vpid_pkg::cmd_t cmd
);

    vpid_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vpid_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = vpid_pkg::OP_NOP;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            vpid_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = vpid_pkg::OP_LOAD;
                    state_next = vpid_pkg::ST_D1;
                end
            end
            vpid_pkg::ST_D1: begin cmd.op = vpid_pkg::OP_D1; state_next = vpid_pkg::ST_D2; end
            vpid_pkg::ST_D2: begin cmd.op = vpid_pkg::OP_D2; state_next = vpid_pkg::ST_D3; end
            vpid_pkg::ST_D3: begin cmd.op = vpid_pkg::OP_D3; state_next = vpid_pkg::ST_D4; end
            vpid_pkg::ST_D4: begin cmd.op = vpid_pkg::OP_D4; state_next = vpid_pkg::ST_D5; end
            vpid_pkg::ST_D5:
            begin
                cmd.op     = vpid_pkg::OP_D5;
                state_next = sts.manual ? vpid_pkg::ST_M1 : vpid_pkg::ST_H1;
            end
            vpid_pkg::ST_M1: begin cmd.op = vpid_pkg::OP_M1; state_next = vpid_pkg::ST_M2; end
            vpid_pkg::ST_M2: begin cmd.op = vpid_pkg::OP_M2; state_next = vpid_pkg::ST_OUT; end
            vpid_pkg::ST_H1: begin cmd.op = vpid_pkg::OP_H1; state_next = vpid_pkg::ST_H2; end
            vpid_pkg::ST_H2: begin cmd.op = vpid_pkg::OP_H2; state_next = vpid_pkg::ST_H3; end
            vpid_pkg::ST_H3: begin cmd.op = vpid_pkg::OP_H3; state_next = vpid_pkg::ST_H4; end
            vpid_pkg::ST_H4: begin cmd.op = vpid_pkg::OP_H4; state_next = vpid_pkg::ST_H5; end
            vpid_pkg::ST_H5: begin cmd.op = vpid_pkg::OP_H5; state_next = vpid_pkg::ST_H6; end
            vpid_pkg::ST_H6: begin cmd.op = vpid_pkg::OP_H6; state_next = vpid_pkg::ST_SQX; end
            vpid_pkg::ST_SQX: begin cmd.op = vpid_pkg::OP_SQ_EXC; state_next = vpid_pkg::ST_WX; end
            vpid_pkg::ST_WX:
                if (sts.sqrt_done)
                    state_next = vpid_pkg::ST_H8;
            vpid_pkg::ST_H8:  begin cmd.op = vpid_pkg::OP_H8;  state_next = vpid_pkg::ST_H9; end
            vpid_pkg::ST_H9:  begin cmd.op = vpid_pkg::OP_H9;  state_next = vpid_pkg::ST_H10; end
            vpid_pkg::ST_H10: begin cmd.op = vpid_pkg::OP_H10; state_next = vpid_pkg::ST_H11; end
            vpid_pkg::ST_H11: begin cmd.op = vpid_pkg::OP_H11; state_next = vpid_pkg::ST_H12; end
            vpid_pkg::ST_H12: begin cmd.op = vpid_pkg::OP_H12; state_next = vpid_pkg::ST_EVAL; end
            vpid_pkg::ST_EVAL:
            begin
                cmd.op     = vpid_pkg::OP_EVAL;
                state_next = sts.big ? vpid_pkg::ST_SQM : vpid_pkg::ST_HINT;
            end
            vpid_pkg::ST_SQM: begin cmd.op = vpid_pkg::OP_SQ_MAG; state_next = vpid_pkg::ST_WM; end
            vpid_pkg::ST_WM:
                if (sts.sqrt_done)
                    state_next = vpid_pkg::ST_MAGN;
            vpid_pkg::ST_MAGN: begin cmd.op = vpid_pkg::OP_MAGN; state_next = vpid_pkg::ST_DVN; end
            vpid_pkg::ST_DVN:  begin cmd.op = vpid_pkg::OP_DIV;  state_next = vpid_pkg::ST_WDN; end
            vpid_pkg::ST_WDN:
                if (sts.div_done)
                    state_next = vpid_pkg::ST_QN;
            vpid_pkg::ST_QN:  begin cmd.op = vpid_pkg::OP_QN;  state_next = vpid_pkg::ST_DVE; end
            vpid_pkg::ST_DVE: begin cmd.op = vpid_pkg::OP_DIV; state_next = vpid_pkg::ST_WDE; end
            vpid_pkg::ST_WDE:
                if (sts.div_done)
                    state_next = vpid_pkg::ST_QE;
            vpid_pkg::ST_QE: begin cmd.op = vpid_pkg::OP_QE; state_next = vpid_pkg::ST_HINT; end
            vpid_pkg::ST_HINT:
                state_next = sts.stop_h ? vpid_pkg::ST_OUT : vpid_pkg::ST_I1;
            vpid_pkg::ST_I1: begin cmd.op = vpid_pkg::OP_I1; state_next = vpid_pkg::ST_I2; end
            vpid_pkg::ST_I2: begin cmd.op = vpid_pkg::OP_I2; state_next = vpid_pkg::ST_I3; end
            vpid_pkg::ST_I3: begin cmd.op = vpid_pkg::OP_I3; state_next = vpid_pkg::ST_I4; end
            vpid_pkg::ST_I4: begin cmd.op = vpid_pkg::OP_I4; state_next = vpid_pkg::ST_I5; end
            vpid_pkg::ST_I5: begin cmd.op = vpid_pkg::OP_I5; state_next = vpid_pkg::ST_I6; end
            vpid_pkg::ST_I6: begin cmd.op = vpid_pkg::OP_I6; state_next = vpid_pkg::ST_SQA; end
            vpid_pkg::ST_SQA: begin cmd.op = vpid_pkg::OP_SQ_INT; state_next = vpid_pkg::ST_WA; end
            vpid_pkg::ST_WA:
                if (sts.sqrt_done)
                    state_next = vpid_pkg::ST_I7;
            vpid_pkg::ST_I7:
            begin
                cmd.op     = vpid_pkg::OP_I7;
                state_next = sts.mag_gt ? vpid_pkg::ST_DVA : vpid_pkg::ST_KEEP;
            end
            vpid_pkg::ST_KEEP: begin cmd.op = vpid_pkg::OP_KEEP; state_next = vpid_pkg::ST_OUT; end
            vpid_pkg::ST_DVA:  begin cmd.op = vpid_pkg::OP_DIV;  state_next = vpid_pkg::ST_WDA; end
            vpid_pkg::ST_WDA:
                if (sts.div_done)
                    state_next = vpid_pkg::ST_QA;
            vpid_pkg::ST_QA:  begin cmd.op = vpid_pkg::OP_QA;  state_next = vpid_pkg::ST_DVB; end
            vpid_pkg::ST_DVB: begin cmd.op = vpid_pkg::OP_DIV; state_next = vpid_pkg::ST_WDB; end
            vpid_pkg::ST_WDB:
                if (sts.div_done)
                    state_next = vpid_pkg::ST_QB;
            vpid_pkg::ST_QB: begin cmd.op = vpid_pkg::OP_QB; state_next = vpid_pkg::ST_OUT; end
            vpid_pkg::ST_OUT:
                // wait until the previous result has been taken
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.op        = vpid_pkg::OP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = vpid_pkg::ST_IDLE;
                end
            default: state_next = vpid_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> rtl/velocity_pid_thrust_antiwindup_unit.sv
// velocity pid thrust unit with anti-windup, top level
// the pid path runs up to three 32-step square roots and up to four 26-step divides
// one transaction is processed at a time; a finished result waits in the output register
// while the next transaction is accepted, and a stalled result holds back the one after it
// reset clears integrators, handshake state and loads the register defaults
module velocity_pid_thrust_antiwindup_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // target_vel_n/e/d, meas_vel_n/e/d, meas_acc_n/e/d, manual_thr_n/e, step_time
    input  logic [vpid_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // thrust_n, thrust_e, thrust_d
    output logic [vpid_pkg::OUT_W-1:0]    m_tdata,
    // down_windup, horiz_windup
    output logic [1:0]                    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vpid_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [vpid_pkg::CDAT_W-1:0]   cfg_data
);

    vpid_pkg::cmd_t cmd;
    vpid_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    vpid_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vpid_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // an accepted transaction keeps the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // the datapath loads only on an input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == vpid_pkg::OP_LOAD) |-> (s_tvalid && s_tready))
        else $error("load without input transaction");

    // the output register is never overwritten while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == vpid_pkg::OP_OUT) |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // square root and divider never finish together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.sqrt_done && sts.div_done))
        else $error("sqrt and divide overlap");

endmodule

>>> tb/sv/tb.sv
// testbench for the velocity pid thrust unit: directed and random stimulus checked against a predictor
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] thr_n;
        logic [15:0] thr_e;
        logic [15:0] thr_d;
        logic        wind_d;
        logic        wind_h;
    } thrust_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [vpid_pkg::IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [vpid_pkg::OUT_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [vpid_pkg::CIDX_W-1:0] cfg_index = '0;
    logic [vpid_pkg::CDAT_W-1:0] cfg_data = '0;

    int errors = 0;
    int idle_send = 0;
    int idle_recv = 0;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    velocity_pid_thrust_antiwindup_unit dut (.*);

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    class thrust_scoreboard;
        logic [47:0] gains_d = '0, gains_h = '0;
        longint hover = 8192, tmin = 1966, tmax_c = 16384, tilt = 4096;
        longint int_n = 0, int_e = 0, int_d = 0;
        thrust_t pending[$];

        function void set_reg(input logic [vpid_pkg::CIDX_W-1:0] idx, input logic [47:0] v);
            case (idx)
                vpid_pkg::CFG_DOWN_GAINS:  gains_d = v;
                vpid_pkg::CFG_HORIZ_GAINS: gains_h = v;
                vpid_pkg::CFG_HOVER:       hover = longint'(v[14:0]);
                vpid_pkg::CFG_MIN_THRUST:  tmin = longint'(v[14:0]);
                vpid_pkg::CFG_MAX_THRUST:  tmax_c = longint'(v[14:0]);
                vpid_pkg::CFG_TILT:        tilt = longint'(v[15:0]);
                default: ;
            endcase
        endfunction

        function void note_input(input logic [vpid_pkg::IN_W-1:0] d);
            longint sp_n, sp_e, en, ee, ed, an, ae, ad, mn, me, dt;
            longint pd, id, dd, ph, ih, dh, umax, umin, td, thd, tn, te, tilt_lim;
            longint dn, de, room, exc, lim, dir, mag, a, b;
            logic [63:0] dsq, tsq;
            bit sd, sh;
            thrust_t r;
            sp_n = longint'($signed(d[15:0]));
            sp_e = longint'($signed(d[31:16]));
            en = sp_n - longint'($signed(d[63:48]));
            ee = sp_e - longint'($signed(d[79:64]));
            ed = longint'($signed(d[47:32])) - longint'($signed(d[95:80]));
            an = longint'($signed(d[111:96]));
            ae = longint'($signed(d[127:112]));
            ad = longint'($signed(d[143:128]));
            mn = longint'($signed(d[159:144]));
            me = longint'($signed(d[175:160]));
            dt = longint'(d[191:176]);
            pd = longint'(gains_d[15:0]);
            id = longint'(gains_d[31:16]);
            dd = longint'(gains_d[47:32]);
            ph = longint'(gains_h[15:0]);
            ih = longint'(gains_h[31:16]);
            dh = longint'(gains_h[47:32]);
            umax = -tmin; umin = -tmax_c;
            sh = 0;
            td = floor_shr(16 * pd * ed + 16 * dd * ad + int_d - 1024 * hover, 10);
            sd = (td >= umax && ed >= 0) || (td <= umin && ed <= 0);
            if (!sd)
                int_d = clip(int_d + floor_shr(ed * id * dt, 12), -1024 * tmax_c, 1024 * tmax_c);
            thd = td < umin ? umin : (td > umax ? umax : td);
            tilt_lim = floor_shr((thd < 0 ? -thd : thd) * tilt, 12);
            if (mn != 0 || me != 0)
            begin
                tn = clip(floor_shr(mn * tilt_lim, 14), -32768, 32767);
                te = clip(floor_shr(me * tilt_lim, 14), -32768, 32767);
            end
            else
            begin
                dn = floor_shr(16 * ph * en + 16 * dh * an + int_n, 10);
                de = floor_shr(16 * ph * ee + 16 * dh * ae + int_e, 10);
                room = tmax_c * tmax_c - thd * thd;
                exc = room > 0 ? int_sqrt(room) : 0;
                lim = tilt_lim < exc ? tilt_lim : exc;
                dsq = 64'(dn * dn) + 64'(de * de);
                tsq = 64'(lim * lim);
                dir = en * sp_n + ee * sp_e;
                tn = dn; te = de;
                if (dsq > tsq)
                begin
                    mag = int_sqrt(dsq);
                    tn = dn * lim / mag;
                    te = de * lim / mag;
                end
                tn = clip(tn, -32768, 32767);
                te = clip(te, -32768, 32767);
                sh = (dsq >= tsq) && dir >= 0;
                if (!sh)
                begin
                    a = clip(int_n + floor_shr(en * ih * dt, 12), -64'sd2147483648, 64'sd2147483647);
                    b = clip(int_e + floor_shr(ee * ih * dt, 12), -64'sd2147483648, 64'sd2147483647);
                    mag = int_sqrt(64'(a * a) + 64'(b * b));
                    if (mag > 1024 * lim)
                    begin
                        a = a * (1024 * lim) / mag;
                        b = b * (1024 * lim) / mag;
                    end
                    int_n = a; int_e = b;
                end
            end
            r.thr_n = tn[15:0];
            r.thr_e = te[15:0];
            r.thr_d = 16'(clip(thd, -32768, 32767));
            r.wind_d = sd;
            r.wind_h = sh;
            pending.push_back(r);
        endfunction

        task check_result(input logic [47:0] d, input logic [1:0] u);
            thrust_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", longint'(d), 0);
                return;
            end
            w = pending.pop_front();
            if (d[15:0] != w.thr_n) report("thrust_n", $signed(d[15:0]), $signed(w.thr_n));
            if (d[31:16] != w.thr_e) report("thrust_e", $signed(d[31:16]), $signed(w.thr_e));
            if (d[47:32] != w.thr_d) report("thrust_d", $signed(d[47:32]), $signed(w.thr_d));
            if (u[0] != w.wind_d) report("down_windup", u[0], w.wind_d);
            if (u[1] != w.wind_h) report("horiz_windup", u[1], w.wind_h);
        endtask
    endclass

    thrust_scoreboard sb = new();

    // result side: random stall and checking
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= idle_recv);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays high after the write; the next input transaction drops it
    task automatic write_reg(input logic [vpid_pkg::CIDX_W-1:0] idx, input logic [47:0] v);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, v);
    endtask

    // valid stays high after the transaction; idling or drain drops it
    task automatic send_item(input logic [vpid_pkg::IN_W-1:0] d);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < idle_send)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata <= d;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_input(d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [15:0] rnd16(input int mag);
        int k;
        k = $urandom_range(9);
        if (k == 0) return 16'h7fff;
        if (k == 1) return 16'h8000;
        if (k < 5) return 16'($urandom);
        return 16'($signed($urandom_range(2 * mag)) - mag);
    endfunction

    function automatic logic [vpid_pkg::IN_W-1:0] rnd_item();
        logic [vpid_pkg::IN_W-1:0] d;
        for (int i = 0; i < 9; i++) d[16*i +: 16] = rnd16(1024);
        if ($urandom_range(3) == 0)
        begin
            d[159:144] = $urandom_range(1) ? rnd16(16384) : 16'h0;
            d[175:160] = rnd16(16384);
        end
        else
            d[175:144] = '0;
        d[191:176] = $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(2000));
        return d;
    endfunction

    function automatic logic [47:0] rnd_gains();
        logic [47:0] g;
        for (int i = 0; i < 3; i++)
            g[16*i +: 16] = $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(8192));
        return g;
    endfunction

    initial
    begin
        logic [vpid_pkg::IN_W-1:0] d;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes with default registers, then random items with gains set
        send_item('0);
        send_item({vpid_pkg::IN_W{1'b1}});
        for (int i = 0; i < 12; i++)
        begin
            d = '0;
            d[16*i +: 16] = i % 2 ? 16'h8000 : 16'h7fff;
            send_item(d);
        end
        drain();
        write_reg(vpid_pkg::CFG_DOWN_GAINS, 48'h1000_0800_2000);
        write_reg(vpid_pkg::CFG_HORIZ_GAINS, 48'h0800_0400_1800);
        for (int i = 0; i < 8; i++)
        begin
            d = rnd_item();
            if (i < 4) d[175:144] = {16'h0, 16'h2000};
            send_item(d);
        end
        drain();
        // swapped thrust limits
        write_reg(vpid_pkg::CFG_MIN_THRUST, 48'(15'h7fff));
        write_reg(vpid_pkg::CFG_MAX_THRUST, 48'(15'd100));
        for (int i = 0; i < 4; i++) send_item(rnd_item());
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph % 4)
                0: begin idle_send = 0; idle_recv = 0; end
                1: begin idle_send = 58; idle_recv = 0; end
                2: begin idle_send = 0; idle_recv = 58; end
                default: begin idle_send = 34; idle_recv = 34; end
            endcase
            write_reg(vpid_pkg::CFG_DOWN_GAINS, ph == 9 ? {48{1'b1}} : rnd_gains());
            write_reg(vpid_pkg::CFG_HORIZ_GAINS, ph == 9 ? {48{1'b1}} : rnd_gains());
            write_reg(vpid_pkg::CFG_HOVER, 48'(ph == 1 ? 15'h0
                                             : (ph == 2 ? 15'h7fff : 15'($urandom_range(16384)))));
            write_reg(vpid_pkg::CFG_MIN_THRUST,
                      48'(ph == 3 ? 15'h7fff : 15'($urandom_range(4000))));
            write_reg(vpid_pkg::CFG_MAX_THRUST, 48'(ph == 4 ? 15'h0 : (ph == 5 ? 15'h7fff
                                                 : 15'($urandom_range(8000, 16384)))));
            write_reg(vpid_pkg::CFG_TILT, 48'(ph == 6 ? 16'h0
                                            : (ph == 7 ? 16'hffff : 16'($urandom_range(8192)))));
            for (int i = 0; i < 100; i++) send_item(rnd_item());
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
